FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the quadratic fit block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define QFIT_AST_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qfit: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define QFIT_AST_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qfit: next-cycle check failed");

`endif

FILE: hdl/qfit_pkg.sv
// ----------------------------------------------------------------------------
// qfit_pkg
// Types, wide-word limits and the saturating magnitude-to-signed helper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qfit_pkg;

    localparam int WIDE_W  = 64;
    localparam int MAG_W   = WIDE_W - 1;
    localparam int HALF_W  = 32;
    localparam int PROD_W  = 2 * WIDE_W;
    localparam int MUL_LAT = 4;
    localparam int DIV_LAT = WIDE_W + 2;

    typedef logic signed [WIDE_W-1:0] t_wide;

    localparam logic [WIDE_W-1:0] WIDE_MAG = 64'd1 << 62;
    localparam t_wide WIDE_MAX = t_wide'(WIDE_MAG - 64'd1);
    localparam t_wide WIDE_MIN = t_wide'(-WIDE_MAG);

    typedef struct packed {
        t_wide val;
        logic  clip;
    } t_wres;

    typedef struct packed {
        logic signed [31:0] x_first;
        logic signed [31:0] x_second;
        logic signed [31:0] x_third;
        logic signed [31:0] y_first;
        logic signed [31:0] y_second;
        logic signed [31:0] y_third;
    } t_in;

    typedef struct packed {
        logic signed [31:0] coef_square;
        logic signed [31:0] coef_linear;
        logic signed [31:0] coef_constant;
        logic               singular;
        logic               saturated;
    } t_out;

    // Apply sign to a magnitude and clip it to the wide word.
    function automatic t_wres f_from_mag(input logic neg, input logic over,
                                         input logic [WIDE_W-1:0] mag);
        t_wres r;
        if (neg) begin
            if (over || mag > WIDE_MAG) begin
                r.val  = WIDE_MIN;
                r.clip = 1'b1;
            end else begin
                r.val  = t_wide'(-mag);
                r.clip = 1'b0;
            end
        end else begin
            if (over || mag > (WIDE_MAG - 64'd1)) begin
                r.val  = WIDE_MAX;
                r.clip = 1'b1;
            end else begin
                r.val  = t_wide'(mag);
                r.clip = 1'b0;
            end
        end
        return r;
    endfunction

endpackage

FILE: hdl/qfit_dly.sv
// ----------------------------------------------------------------------------
// qfit_dly
// Delay line that carries a valid bit and side data next to a unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qfit_dly
    import qfit_pkg::*;
#(
    parameter int W = 8,
    parameter int D = 1
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic         i_vld,
    input  logic [W-1:0] i_data,
    output logic         o_vld,
    output logic [W-1:0] o_data
);

    logic         r_vld  [0:D-1];
    logic [W-1:0] r_data [0:D-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data[0] <= i_data;
        end
    end

    for (genvar k = 1; k < D; k++) begin : g_tap
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= r_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_data[k] <= r_data[k-1];
            end
        end
    end

    assign o_vld  = r_vld[D-1];
    assign o_data = r_data[D-1];

endmodule

FILE: hdl/qfit_mul.sv
// ----------------------------------------------------------------------------
// qfit_mul
// Pipelined wide fixed-point product: (a*b) >> FRAC_BITS on magnitudes,
// truncated toward zero and clipped to the wide word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qfit_mul
    import qfit_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic  i_clk,
    input  logic  i_en,
    input  t_wide i_a,
    input  t_wide i_b,
    output t_wide o_res,
    output logic  o_clip
);

    t_wide              n_a_abs;
    t_wide              n_b_abs;
    logic [MAG_W-1:0]   r_ma;
    logic [MAG_W-1:0]   r_mb;
    logic               r_neg1;
    logic               r_neg2;
    logic               r_neg3;
    logic [2*HALF_W-1:0]        r_ll;
    logic [2*HALF_W-2:0]        r_lh;
    logic [2*HALF_W-2:0]        r_hl;
    logic [2*(MAG_W-HALF_W)-1:0] r_hh;
    logic [PROD_W-1:0]  r_prod;
    logic [PROD_W-1:0]  w_sh;
    t_wres              w_res;
    t_wres              r_res;

    assign n_a_abs = i_a[WIDE_W-1] ? -i_a : i_a;
    assign n_b_abs = i_b[WIDE_W-1] ? -i_b : i_b;

    // Split into a 32-bit low and a 31-bit high part, sum the partial products, then scale and clip.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ma   <= n_a_abs[MAG_W-1:0];
            r_mb   <= n_b_abs[MAG_W-1:0];
            r_neg1 <= i_a[WIDE_W-1] ^ i_b[WIDE_W-1];

            r_ll   <= r_ma[HALF_W-1:0] * r_mb[HALF_W-1:0];
            r_lh   <= r_ma[HALF_W-1:0] * r_mb[MAG_W-1:HALF_W];
            r_hl   <= r_ma[MAG_W-1:HALF_W] * r_mb[HALF_W-1:0];
            r_hh   <= r_ma[MAG_W-1:HALF_W] * r_mb[MAG_W-1:HALF_W];
            r_neg2 <= r_neg1;

            r_prod <= PROD_W'(r_ll)
                    + (PROD_W'(r_lh) << HALF_W)
                    + (PROD_W'(r_hl) << HALF_W)
                    + (PROD_W'(r_hh) << (2 * HALF_W));
            r_neg3 <= r_neg2;

            r_res  <= w_res;
        end
    end

    assign w_sh  = r_prod >> FRAC_BITS;
    assign w_res = f_from_mag(r_neg3, |w_sh[PROD_W-1:WIDE_W], w_sh[WIDE_W-1:0]);

    assign o_res  = r_res.val;
    assign o_clip = r_res.clip;

endmodule

FILE: hdl/qfit_div.sv
// ----------------------------------------------------------------------------
// qfit_div
// Pipelined restoring divider: (|num| << FRAC_BITS) / |den|, one quotient
// bit per stage, truncated toward zero and clipped to the wide word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qfit_div
    import qfit_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic  i_clk,
    input  logic  i_en,
    input  t_wide i_num,
    input  t_wide i_den,
    output t_wide o_res,
    output logic  o_clip
);

    t_wide             n_up;
    t_wide             n_dn;
    logic [PROD_W-1:0] n_nf;
    logic              n_over;

    logic [WIDE_W-1:0] r_rem  [0:WIDE_W];
    logic [WIDE_W-1:0] r_w    [0:WIDE_W];
    logic [WIDE_W-1:0] r_d    [0:WIDE_W];
    logic              r_neg  [0:WIDE_W];
    logic              r_over [0:WIDE_W];
    t_wres             r_res;

    assign n_up   = i_num[WIDE_W-1] ? -i_num : i_num;
    assign n_dn   = i_den[WIDE_W-1] ? -i_den : i_den;
    assign n_nf   = PROD_W'(unsigned'(n_up)) << FRAC_BITS;
    // Quotient needs more than 64 bits: clip without running the steps.
    assign n_over = n_nf[PROD_W-1:WIDE_W] >= unsigned'(n_dn);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= n_nf[PROD_W-1:WIDE_W];
            r_w[0]    <= n_nf[WIDE_W-1:0];
            r_d[0]    <= unsigned'(n_dn);
            r_neg[0]  <= i_num[WIDE_W-1] ^ i_den[WIDE_W-1];
            r_over[0] <= n_over;
        end
    end

    // Shift in one numerator bit, subtract when it fits, shift in the quotient bit.
    for (genvar k = 0; k < WIDE_W; k++) begin : g_step
        logic [WIDE_W-1:0] w_rs;
        logic              w_ge;

        assign w_rs = {r_rem[k][WIDE_W-2:0], r_w[k][WIDE_W-1]};
        assign w_ge = w_rs >= r_d[k];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]  <= w_ge ? (w_rs - r_d[k]) : w_rs;
                r_w[k+1]    <= {r_w[k][WIDE_W-2:0], w_ge};
                r_d[k+1]    <= r_d[k];
                r_neg[k+1]  <= r_neg[k];
                r_over[k+1] <= r_over[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= f_from_mag(r_neg[WIDE_W], r_over[WIDE_W], r_w[WIDE_W]);
        end
    end

    assign o_res  = r_res.val;
    assign o_clip = r_res.clip;

endmodule

FILE: hdl/quadratic_fit_three_points_unit.sv
// ----------------------------------------------------------------------------
// quadratic_fit_three_points_unit
// Fits y = a*x^2 + b*x + c through three points by pivoted elimination of
// the matrix [1, x, x^2 | y] and back substitution, in signed fixed point.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+-------------
//   in      | input     | i_in_valid / o_in_stall    | i_in_data
//   out     | output    | o_out_valid / i_out_stall  | o_out_data
//
// One transaction enters per cycle while o_in_stall is low; a result passes
// through three 66-stage dividers, four 4-stage multiplier groups, six
// elimination/substitution stages and the output register.
// Reset (synchronous, active low) empties every stage; no clearing pass.
// Output stall: a skid register takes one more result, then o_in_stall
// rises and the whole pipeline holds until the skid drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module quadratic_fit_three_points_unit
    import qfit_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    // Rows after the first column: row 0 plus the two differences from it.
    typedef struct packed {
        t_wide m01, m02, m03, d11, d12, d13, d21, d22, d23;
        logic  sat;
    } t_e1;

    // Pivot row, remaining row and flags after the second column pivot.
    typedef struct packed {
        t_wide m01, m02, m03, p11, p12, p13, o21, o22, o23;
        logic  sing;
        logic  sat;
    } t_e2;

    typedef struct packed {
        t_wide m01, m02, m03, p11, p12, p13, o22, o23;
        logic  sing;
        logic  sat;
    } t_sa;

    typedef struct packed {
        t_wide m01, m02, m03, p11, p12, p13, q22, q23;
        logic  sing;
        logic  sat;
    } t_s1;

    typedef struct packed {
        t_wide m01, m02, m03, p11, p12, p13;
        logic  sing;
        logic  sat;
    } t_sc;

    typedef struct packed {
        t_wide m01, m03, p11, p13, sol2;
        logic  sing;
        logic  sat;
    } t_sd;

    typedef struct packed {
        t_wide m01, t0a, t1, p11, sol2;
        logic  sing;
        logic  sat;
    } t_s2;

    typedef struct packed {
        t_wide m01, t0a, sol2;
        logic  sing;
        logic  sat;
    } t_se;

    typedef struct packed {
        t_wide t0a, sol2, sol1;
        logic  sing;
        logic  sat;
    } t_sf;

    typedef struct packed {
        t_wide sol0, sol1, sol2;
        logic  sing;
        logic  sat;
    } t_s3;

    typedef struct packed {
        logic signed [31:0] val;
        logic               clip;
    } t_c32;

    localparam t_wide TOP32 = (t_wide'(1) <<< 31) - t_wide'(1);
    localparam t_wide BOT32 = -(t_wide'(1) <<< 31);

    // Exact difference, clipped to the wide word.
    function automatic t_wres f_wsub(input t_wide p, input t_wide q);
        logic signed [WIDE_W:0] s;
        t_wres                  r;
        s = (WIDE_W+1)'(p) - (WIDE_W+1)'(q);
        if (s > (WIDE_W+1)'(WIDE_MAX)) begin
            r.val  = WIDE_MAX;
            r.clip = 1'b1;
        end else if (s < (WIDE_W+1)'(WIDE_MIN)) begin
            r.val  = WIDE_MIN;
            r.clip = 1'b1;
        end else begin
            r.val  = t_wide'(s);
            r.clip = 1'b0;
        end
        return r;
    endfunction

    function automatic t_c32 f_clip32(input t_wide v);
        t_c32 r;
        if (v > TOP32) begin
            r.val  = TOP32[31:0];
            r.clip = 1'b1;
        end else if (v < BOT32) begin
            r.val  = BOT32[31:0];
            r.clip = 1'b1;
        end else begin
            r.val  = v[31:0];
            r.clip = 1'b0;
        end
        return r;
    endfunction

    logic  w_adv;
    logic  w_take;

    // Squares of the abscissas
    t_wide w_sq0, w_sq1, w_sq2;
    logic  w_sq0_clip, w_sq1_clip, w_sq2_clip;
    logic  w_pt_vld;
    t_in   w_pt;

    t_e1   n_e1, r_e1;
    logic  r_e1_vld;
    t_e2   n_e2, r_e2;
    logic  r_e2_vld;

    // Multiplier factor for the remaining row
    t_wide w_fa;
    logic  w_fa_clip;
    logic  w_sa_vld;
    t_sa   w_sa, n_sb;

    t_wide w_pb2, w_pb3;
    logic  w_pb2_clip, w_pb3_clip;
    logic  w_sb_vld;
    t_sa   w_sb;

    t_s1   n_s1, r_s1;
    logic  r_s1_vld;
    t_wres w_q22, w_q23;

    t_wide w_sol2;
    logic  w_sol2_clip;
    logic  w_sc_vld;
    t_sc   w_sc;
    t_sd   n_sd, w_sd;
    logic  w_sd_vld;

    t_wide w_pd1, w_pd0;
    logic  w_pd1_clip, w_pd0_clip;

    t_s2   n_s2, r_s2;
    logic  r_s2_vld;
    t_wres w_t1, w_t0a;

    t_wide w_sol1;
    logic  w_sol1_clip;
    logic  w_se_vld;
    t_se   w_se;
    t_sf   n_sf, w_sf;
    logic  w_sf_vld;

    t_wide w_pf;
    logic  w_pf_clip;

    t_s3   n_s3, r_s3;
    logic  r_s3_vld;
    t_wres w_sol0;

    t_out  n_s4, r_s4;
    logic  r_s4_vld;
    t_c32  w_ca, w_cb, w_cc;

    t_out  r_out, r_skid;
    logic  r_out_vld, r_skid_vld;

    // Advance every stage up to r_s4 unless the skid register is holding a result.
    assign w_adv      = !r_skid_vld;
    assign w_take     = r_out_vld && !i_out_stall;
    assign o_in_stall = r_skid_vld;

    // ---------------- squares of x ----------------
    qfit_mul #(.FRAC_BITS(FRAC_BITS)) u_sq0 (
        .i_clk (i_clk), .i_en (w_adv),
        .i_a (t_wide'(i_in_data.x_first)), .i_b (t_wide'(i_in_data.x_first)),
        .o_res (w_sq0), .o_clip (w_sq0_clip)
    );
    qfit_mul #(.FRAC_BITS(FRAC_BITS)) u_sq1 (
        .i_clk (i_clk), .i_en (w_adv),
        .i_a (t_wide'(i_in_data.x_second)), .i_b (t_wide'(i_in_data.x_second)),
        .o_res (w_sq1), .o_clip (w_sq1_clip)
    );
    qfit_mul #(.FRAC_BITS(FRAC_BITS)) u_sq2 (
        .i_clk (i_clk), .i_en (w_adv),
        .i_a (t_wide'(i_in_data.x_third)), .i_b (t_wide'(i_in_data.x_third)),
        .o_res (w_sq2), .o_clip (w_sq2_clip)
    );
    qfit_dly #(.W($bits(t_in)), .D(MUL_LAT)) u_dly_pt (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_adv),
        .i_vld (i_in_valid), .i_data (i_in_data),
        .o_vld (w_pt_vld), .o_data (w_pt)
    );

    // ---------------- first column ----------------
    // Every row holds 1.0 here, so row 0 pivots and the factor is exactly 1.0:
    // subtract row 0 from rows 1 and 2.
    always_comb begin
        n_e1.m01 = t_wide'(w_pt.x_first);
        n_e1.m02 = w_sq0;
        n_e1.m03 = t_wide'(w_pt.y_first);
        n_e1.d11 = t_wide'(w_pt.x_second) - t_wide'(w_pt.x_first);
        n_e1.d12 = w_sq1 - w_sq0;
        n_e1.d13 = t_wide'(w_pt.y_second) - t_wide'(w_pt.y_first);
        n_e1.d21 = t_wide'(w_pt.x_third) - t_wide'(w_pt.x_first);
        n_e1.d22 = w_sq2 - w_sq0;
        n_e1.d23 = t_wide'(w_pt.y_third) - t_wide'(w_pt.y_first);
        n_e1.sat = w_sq0_clip | w_sq1_clip | w_sq2_clip;
    end

    // ---------------- second column pivot ----------------
    // Greater signed entry wins; on a tie row 1 stays.
    always_comb begin
        n_e2.m01  = r_e1.m01;
        n_e2.m02  = r_e1.m02;
        n_e2.m03  = r_e1.m03;
        n_e2.sat  = r_e1.sat;
        if (r_e1.d21 > r_e1.d11) begin
            n_e2.p11 = r_e1.d21;
            n_e2.p12 = r_e1.d22;
            n_e2.p13 = r_e1.d23;
            n_e2.o21 = r_e1.d11;
            n_e2.o22 = r_e1.d12;
            n_e2.o23 = r_e1.d13;
        end else begin
            n_e2.p11 = r_e1.d11;
            n_e2.p12 = r_e1.d12;
            n_e2.p13 = r_e1.d13;
            n_e2.o21 = r_e1.d21;
            n_e2.o22 = r_e1.d22;
            n_e2.o23 = r_e1.d23;
        end
        n_e2.sing = (n_e2.p11 == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e1_vld <= 1'b0;
            r_e2_vld <= 1'b0;
        end else if (w_adv) begin
            r_e1_vld <= w_pt_vld;
            r_e2_vld <= r_e1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_e1 <= n_e1;
            r_e2 <= n_e2;
        end
    end

    // ---------------- elimination factor ----------------
    qfit_div #(.FRAC_BITS(FRAC_BITS)) u_div_fa (
        .i_clk (i_clk), .i_en (w_adv),
        .i_num (r_e2.o21), .i_den (r_e2.p11),
        .o_res (w_fa), .o_clip (w_fa_clip)
    );
    qfit_dly #(.W($bits(t_sa)), .D(DIV_LAT)) u_dly_sa (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_adv),
        .i_vld (r_e2_vld),
        .i_data ({r_e2.m01, r_e2.m02, r_e2.m03, r_e2.p11, r_e2.p12, r_e2.p13,
                  r_e2.o22, r_e2.o23, r_e2.sing, r_e2.sat}),
        .o_vld (w_sa_vld), .o_data (w_sa)
    );

    // ---------------- factor times pivot row ----------------
    always_comb begin
        n_sb     = w_sa;
        n_sb.sat = w_sa.sat | w_fa_clip;
    end

    qfit_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_b2 (
        .i_clk (i_clk), .i_en (w_adv),
        .i_a (w_fa), .i_b (w_sa.p12),
        .o_res (w_pb2), .o_clip (w_pb2_clip)
    );
    qfit_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_b3 (
        .i_clk (i_clk), .i_en (w_adv),
        .i_a (w_fa), .i_b (w_sa.p13),
        .o_res (w_pb3), .o_clip (w_pb3_clip)
    );
    qfit_dly #(.W($bits(t_sa)), .D(MUL_LAT)) u_dly_sb (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_adv),
        .i_vld (w_sa_vld), .i_data (n_sb),
        .o_vld (w_sb_vld), .o_data (w_sb)
    );

    // ---------------- remaining row update, third pivot ----------------
    assign w_q22 = f_wsub(w_sb.o22, w_pb2);
    assign w_q23 = f_wsub(w_sb.o23, w_pb3);

    always_comb begin
        n_s1.m01  = w_sb.m01;
        n_s1.m02  = w_sb.m02;
        n_s1.m03  = w_sb.m03;
        n_s1.p11  = w_sb.p11;
        n_s1.p12  = w_sb.p12;
        n_s1.p13  = w_sb.p13;
        n_s1.q22  = w_q22.val;
        n_s1.q23  = w_q23.val;
        n_s1.sing = w_sb.sing | (w_q22.val == '0);
        n_s1.sat  = w_sb.sat | w_pb2_clip | w_pb3_clip | w_q22.clip | w_q23.clip;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_adv) begin
            r_s1_vld <= w_sb_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1 <= n_s1;
        end
    end

    // ---------------- a = q23 / q22 ----------------
    qfit_div #(.FRAC_BITS(FRAC_BITS)) u_div_a (
        .i_clk (i_clk), .i_en (w_adv),
        .i_num (r_s1.q23), .i_den (r_s1.q22),
        .o_res (w_sol2), .o_clip (w_sol2_clip)
    );
    qfit_dly #(.W($bits(t_sc)), .D(DIV_LAT)) u_dly_sc (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_adv),
        .i_vld (r_s1_vld),
        .i_data ({r_s1.m01, r_s1.m02, r_s1.m03, r_s1.p11, r_s1.p12, r_s1.p13,
                  r_s1.sing, r_s1.sat}),
        .o_vld (w_sc_vld), .o_data (w_sc)
    );

    // ---------------- a times row 1 and row 0 ----------------
    always_comb begin
        n_sd.m01  = w_sc.m01;
        n_sd.m03  = w_sc.m03;
        n_sd.p11  = w_sc.p11;
        n_sd.p13  = w_sc.p13;
        n_sd.sol2 = w_sol2;
        n_sd.sing = w_sc.sing;
        n_sd.sat  = w_sc.sat | w_sol2_clip;
    end

    qfit_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_d1 (
        .i_clk (i_clk), .i_en (w_adv),
        .i_a (w_sc.p12), .i_b (w_sol2),
        .o_res (w_pd1), .o_clip (w_pd1_clip)
    );
    qfit_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_d0 (
        .i_clk (i_clk), .i_en (w_adv),
        .i_a (w_sc.m02), .i_b (w_sol2),
        .o_res (w_pd0), .o_clip (w_pd0_clip)
    );
    qfit_dly #(.W($bits(t_sd)), .D(MUL_LAT)) u_dly_sd (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_adv),
        .i_vld (w_sc_vld), .i_data (n_sd),
        .o_vld (w_sd_vld), .o_data (w_sd)
    );

    // ---------------- subtract the a terms ----------------
    assign w_t1  = f_wsub(w_sd.p13, w_pd1);
    assign w_t0a = f_wsub(w_sd.m03, w_pd0);

    always_comb begin
        n_s2.m01  = w_sd.m01;
        n_s2.t0a  = w_t0a.val;
        n_s2.t1   = w_t1.val;
        n_s2.p11  = w_sd.p11;
        n_s2.sol2 = w_sd.sol2;
        n_s2.sing = w_sd.sing;
        n_s2.sat  = w_sd.sat | w_pd1_clip | w_pd0_clip | w_t1.clip | w_t0a.clip;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (w_adv) begin
            r_s2_vld <= w_sd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s2 <= n_s2;
        end
    end

    // ---------------- b = t1 / pivot ----------------
    qfit_div #(.FRAC_BITS(FRAC_BITS)) u_div_b (
        .i_clk (i_clk), .i_en (w_adv),
        .i_num (r_s2.t1), .i_den (r_s2.p11),
        .o_res (w_sol1), .o_clip (w_sol1_clip)
    );
    qfit_dly #(.W($bits(t_se)), .D(DIV_LAT)) u_dly_se (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_adv),
        .i_vld (r_s2_vld),
        .i_data ({r_s2.m01, r_s2.t0a, r_s2.sol2, r_s2.sing, r_s2.sat}),
        .o_vld (w_se_vld), .o_data (w_se)
    );

    // ---------------- b times row 0 ----------------
    always_comb begin
        n_sf.t0a  = w_se.t0a;
        n_sf.sol2 = w_se.sol2;
        n_sf.sol1 = w_sol1;
        n_sf.sing = w_se.sing;
        n_sf.sat  = w_se.sat | w_sol1_clip;
    end

    qfit_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_f (
        .i_clk (i_clk), .i_en (w_adv),
        .i_a (w_se.m01), .i_b (w_sol1),
        .o_res (w_pf), .o_clip (w_pf_clip)
    );
    qfit_dly #(.W($bits(t_sf)), .D(MUL_LAT)) u_dly_sf (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_adv),
        .i_vld (w_se_vld), .i_data (n_sf),
        .o_vld (w_sf_vld), .o_data (w_sf)
    );

    // ---------------- c; the division by 1.0 is exact ----------------
    assign w_sol0 = f_wsub(w_sf.t0a, w_pf);

    always_comb begin
        n_s3.sol0 = w_sol0.val;
        n_s3.sol1 = w_sf.sol1;
        n_s3.sol2 = w_sf.sol2;
        n_s3.sing = w_sf.sing;
        n_s3.sat  = w_sf.sat | w_pf_clip | w_sol0.clip;
    end

    // ---------------- clip to 32 bits, singular override ----------------
    assign w_ca = f_clip32(r_s3.sol2);
    assign w_cb = f_clip32(r_s3.sol1);
    assign w_cc = f_clip32(r_s3.sol0);

    always_comb begin
        if (r_s3.sing) begin
            n_s4.coef_square   = '0;
            n_s4.coef_linear   = '0;
            n_s4.coef_constant = '0;
            n_s4.singular      = 1'b1;
            n_s4.saturated     = 1'b0;
        end else begin
            n_s4.coef_square   = w_ca.val;
            n_s4.coef_linear   = w_cb.val;
            n_s4.coef_constant = w_cc.val;
            n_s4.singular      = 1'b0;
            n_s4.saturated     = r_s3.sat | w_ca.clip | w_cb.clip | w_cc.clip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
        end else if (w_adv) begin
            r_s3_vld <= w_sf_vld;
            r_s4_vld <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s3 <= n_s3;
            r_s4 <= n_s4;
        end
    end

    // ---------------- output register and skid ----------------
    // Drain the skid first; otherwise load the output register when it is
    // free, else park the leaving result in the skid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (w_take) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end
        end else if (!r_out_vld || w_take) begin
            r_out_vld <= r_s4_vld;
        end else if (r_s4_vld) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (w_take) begin
                r_out <= r_skid;
            end
        end else if (!r_out_vld || w_take) begin
            r_out <= r_s4;
        end else begin
            r_skid <= r_s4;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // ---------------- checks ----------------
    `QFIT_AST_IMP(a_skid_has_out, i_clk, i_rst_n, r_skid_vld, r_out_vld)
    `QFIT_AST_NXT(a_skid_only_on_stall, i_clk, i_rst_n, !r_skid_vld && !(r_out_vld && i_out_stall), !r_skid_vld)
    `QFIT_AST_NXT(a_skid_holds, i_clk, i_rst_n, r_skid_vld && i_out_stall, r_skid_vld && r_out_vld)
    `QFIT_AST_IMP(a_singular_zero, i_clk, i_rst_n, r_out_vld && r_out.singular, r_out.coef_square == '0 && r_out.coef_linear == '0 && r_out.coef_constant == '0 && !r_out.saturated)

endmodule
